[hdl/prefix_code_decoder_top_assert.svh]
// ----------------------------------------------------------------------------
// Prefix code decoder assertion macros
// Shorthand for clocked property checks with the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_DECODER_TOP_ASSERT_SVH
`define PREFIX_CODE_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pcd_pkg.sv]
// ----------------------------------------------------------------------------
// Prefix code decoder package
// Field widths, opcodes, transaction payload types and the code mask helper.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int CODE_W = 32;
	localparam int CLEN_W = 6;
	localparam int SYM_W  = 8;
	localparam int DATA_W = 8;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DATA = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [CODE_W-1:0] code_bits;
		logic [CLEN_W-1:0] code_length;
		logic [DATA_W-1:0] data_byte;
		logic [CNT_W-1:0]  bit_count;
		logic              final_byte;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             error_flag;
		logic             last;
	} out_item_t;

	// Keeps only the low len bits of a code; lengths of 32 and above keep all.
	function automatic logic [CODE_W-1:0] code_mask(input logic [CODE_W-1:0] value,
			input logic [CLEN_W-1:0] len);
		logic [CODE_W-1:0] m;
		if (len >= CLEN_W'(CODE_W)) begin
			m = '1;
		end else begin
			m = (CODE_W'(1) << len) - CODE_W'(1);
		end
		return value & m;
	endfunction

endpackage

[hdl/pcd_stream_if.sv]
// ----------------------------------------------------------------------------
// Prefix code decoder stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pcd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/prefix_code_decoder_top.sv]
// ----------------------------------------------------------------------------
// Prefix code decoder top level
// Decodes a prefix-coded bit stream into byte symbols, one bit at a time,
// matching the accumulated bits against a code table held in RAM.
// ----------------------------------------------------------------------------
//
// Channel   Role    Payload     Transaction carries
// item      sink    in_item_t   one table load or one coded data byte
// result    source  out_item_t  one decoded symbol or one overflow error
//
// A data transaction is accepted, then each valid bit enters the accumulator;
// when no stored code has the new accumulated length the bit skips the table
// sweep (or ends in an overflow error when it fills the accumulator), and
// otherwise the single RAM read port is swept from the highest entry down,
// one entry per cycle, and a hit ends the sweep early (a sweep that misses at
// the full length ends in an overflow error). A flush step closes the byte.
// Reset clears the accumulator and the length map and needs no clearing pass.
// A stalled result port holds the decoder in its result or flush step.
// ----------------------------------------------------------------------------
`include "prefix_code_decoder_top_assert.svh"

module prefix_code_decoder_top import pcd_pkg::*; #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input logic          clk,
	input logic          arst_n,
	pcd_stream_if.sink   item,
	pcd_stream_if.source result
);
	// Table address, accumulated length and compare widths.
	localparam int IW    = $clog2(SYMBOL_COUNT);
	localparam int LW    = $clog2(MAX_CODE_LEN + 1);
	localparam int LCW   = (LW > CLEN_W) ? LW : CLEN_W;
	localparam int CW    = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int RAM_W = CLEN_W + CODE_W;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_BIT    = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_RESULT = 6'b001000,
		ST_NEXT   = 6'b010000,
		ST_FLUSH  = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [MAX_CODE_LEN-1:0] acc_q;
	logic [LW-1:0]           len_q;
	logic [MAX_CODE_LEN:0]   present_q;
	logic                    scan_more_q;
	logic                    rd_vld_s1;
	logic                    pend_vld_q;
	logic                    out_vld_q;

	logic [DATA_W-1:0]       data_q;
	logic [CNT_W-1:0]        bits_left_q;
	logic                    fin_q;
	logic [IW-1:0]           scan_idx_q;
	logic [IW-1:0]           rd_idx_s1;
	logic [SYM_W-1:0]        res_sym_q;
	logic                    res_err_q;
	logic [SYM_W-1:0]        pend_sym_q;
	logic                    pend_err_q;
	out_item_t               out_q;

	logic                    in_fire;
	logic                    is_load;
	logic                    table_we;
	logic                    len_ok;
	logic [RAM_W-1:0]        table_wdata;
	logic [RAM_W-1:0]        rd_data;
	logic [CLEN_W-1:0]       rd_len;
	logic [CODE_W-1:0]       rd_val;
	logic [CNT_W-1:0]        count_in;
	logic [2:0]              bit_sel;
	logic [LW-1:0]           new_len;
	logic [MAX_CODE_LEN-1:0] acc_shift;
	logic                    bit_go_scan;
	logic                    bit_err;
	logic                    scan_hit;
	logic                    scan_done;
	logic                    scan_err;
	logic                    out_free;
	logic                    res_take;
	logic                    push_mid;
	logic                    push_last;

	// The code table: each word holds the code length above the masked code.
	assign in_fire     = item.valid && item.ready;
	assign is_load     = item.payload.opcode == OP_LOAD;
	assign table_we    = in_fire && is_load && (int'(item.payload.entry_index) < SYMBOL_COUNT);
	assign table_wdata = {item.payload.code_length,
		code_mask(item.payload.code_bits, item.payload.code_length)};
	assign len_ok      = (item.payload.code_length != '0) &&
		(int'(item.payload.code_length) <= MAX_CODE_LEN);

	pcd_ram #(
		.WIDTH (RAM_W),
		.DEPTH (SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.we    (table_we),
		.waddr (item.payload.entry_index[IW-1:0]),
		.wdata (table_wdata),
		.raddr (scan_idx_q),
		.rdata (rd_data)
	);

	assign rd_len = rd_data[RAM_W-1 -: CLEN_W];
	assign rd_val = rd_data[CODE_W-1:0];

	// A bit count of zero or above eight means a full byte.
	assign count_in = ((item.payload.bit_count == '0) ||
		(item.payload.bit_count > CNT_W'(DATA_W))) ? CNT_W'(DATA_W) : item.payload.bit_count;

	// Bits are taken from the most significant valid position downward.
	assign bit_sel   = 3'(bits_left_q - CNT_W'(1));
	assign new_len   = LW'(len_q + LW'(1));
	assign acc_shift = {acc_q[MAX_CODE_LEN-2:0], data_q[bit_sel]};

	// The length map lets a bit skip the table sweep when no code of the new
	// length was ever loaded. Stale marks only cost a wasted sweep.
	assign bit_go_scan = (state_q == ST_BIT) && present_q[new_len];
	assign bit_err     = (state_q == ST_BIT) && !present_q[new_len] &&
		(int'(new_len) >= MAX_CODE_LEN);

	// The sweep runs from the highest index down, so the first hit is the
	// winner when several entries hold the same code.
	assign scan_hit  = (state_q == ST_SCAN) && rd_vld_s1 &&
		(LCW'(rd_len) == LCW'(len_q)) && (CW'(rd_val) == CW'(acc_q));
	assign scan_done = (state_q == ST_SCAN) && !rd_vld_s1 && !scan_more_q;
	assign scan_err  = scan_done && (int'(len_q) >= MAX_CODE_LEN);

	// A result is held back one step in the pending register, since only the
	// next result or the end of the byte tells whether it is the last one.
	assign out_free  = !out_vld_q || result.ready;
	assign res_take  = (state_q == ST_RESULT) && (!pend_vld_q || out_free);
	assign push_mid  = res_take && pend_vld_q;
	assign push_last = (state_q == ST_FLUSH) && pend_vld_q && out_free;

	assign item.ready     = state_q == ST_IDLE;
	assign result.valid   = out_vld_q;
	assign result.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			len_q       <= '0;
			present_q   <= '0;
			scan_more_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && scan_more_q && !scan_hit;
			if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (table_we && len_ok) begin
						present_q[LW'(item.payload.code_length)] <= 1'b1;
					end
					if (in_fire && !is_load) begin
						state_q <= ST_BIT;
					end
				end
				ST_BIT: begin
					if (bit_go_scan) begin
						acc_q       <= acc_shift;
						len_q       <= new_len;
						scan_more_q <= 1'b1;
						state_q     <= ST_SCAN;
					end else if (bit_err) begin
						acc_q   <= '0;
						len_q   <= '0;
						state_q <= ST_RESULT;
					end else begin
						acc_q   <= acc_shift;
						len_q   <= new_len;
						state_q <= ST_NEXT;
					end
				end
				ST_SCAN: begin
					if (scan_more_q && (scan_idx_q == '0)) begin
						scan_more_q <= 1'b0;
					end
					if (scan_hit || scan_err) begin
						acc_q       <= '0;
						len_q       <= '0;
						scan_more_q <= 1'b0;
						state_q     <= ST_RESULT;
					end else if (scan_done) begin
						state_q <= ST_NEXT;
					end
				end
				ST_RESULT: begin
					if (res_take) begin
						pend_vld_q <= 1'b1;
						state_q    <= ST_NEXT;
					end
					if (push_mid) begin
						out_vld_q <= 1'b1;
					end
				end
				ST_NEXT: begin
					if (bits_left_q != '0) begin
						state_q <= ST_BIT;
					end else begin
						if (fin_q) begin
							acc_q <= '0;
							len_q <= '0;
						end
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (push_last) begin
						out_vld_q  <= 1'b1;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !is_load) begin
			data_q      <= item.payload.data_byte;
			fin_q       <= item.payload.final_byte;
			bits_left_q <= count_in;
		end
		if (state_q == ST_BIT) begin
			bits_left_q <= bits_left_q - CNT_W'(1);
		end
		if (bit_go_scan) begin
			scan_idx_q <= IW'(SYMBOL_COUNT - 1);
		end else if ((state_q == ST_SCAN) && scan_more_q) begin
			scan_idx_q <= scan_idx_q - IW'(1);
		end
		rd_idx_s1 <= scan_idx_q;
		if (scan_hit) begin
			res_sym_q <= SYM_W'(rd_idx_s1);
			res_err_q <= 1'b0;
		end else if (bit_err || scan_err) begin
			res_sym_q <= '0;
			res_err_q <= 1'b1;
		end
		if (push_mid) begin
			out_q <= '{symbol: pend_sym_q, error_flag: pend_err_q, last: 1'b0};
		end else if (push_last) begin
			out_q <= '{symbol: pend_sym_q, error_flag: pend_err_q, last: 1'b1};
		end
		if (res_take) begin
			pend_sym_q <= res_sym_q;
			pend_err_q <= res_err_q;
		end
	end

	// The accumulator never holds more bits than the longest code.
	`PCD_ASSERT_NOW(a_len_bound, 1'b1, int'(len_q) <= MAX_CODE_LEN, "accumulated length overflow")
	// Every result of a byte has been handed on before the next transaction.
	`PCD_ASSERT_NOW(a_idle_flushed, state_q == ST_IDLE, !pend_vld_q, "pending result left at idle")
	// A sweep only runs for a nonempty accumulator whose length has codes.
	`PCD_ASSERT_NOW(a_scan_len, state_q == ST_SCAN, (len_q != '0) && present_q[len_q], "sweep without codes of this length")
	// A hit clears the accumulator and moves on to hand over the symbol.
	`PCD_ASSERT_NEXT(a_hit_clears, scan_hit, (state_q == ST_RESULT) && (len_q == '0), "hit did not clear the accumulator")
endmodule

[hdl/pcd_ram.sv]
// ----------------------------------------------------------------------------
// Prefix code decoder RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module pcd_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
